FILE: rtl/hbb_pkg.sv
// ----------------------------------------------------------------------------
// hbb_pkg: shared types and constants for the homography bounding box unit
// Fixed-point widths, register map codes and the divider result bundle.
// ----------------------------------------------------------------------------
package hbb_pkg;

	localparam int COORD_BITS     = 12;
	localparam int OUT_BITS       = 21;
	localparam int COEF_FRAC_BITS = 32;
	localparam int COEF_W         = 48;
	localparam int NUM_REGS       = 8;

	// Exact numerator/denominator: three terms of up to COEF_W+COORD_BITS bits
	localparam int ACC_W  = COEF_W + COORD_BITS + 2;
	localparam int PROD_W = COEF_W + COORD_BITS + 1;
	// 2|N| + |D| needs one bit more than the signed accumulator
	localparam int NUM_W  = ACC_W + 1;
	// Quotient bits examined: OUT_BITS magnitude bits plus one overflow bit
	localparam int QUO_W  = OUT_BITS + 1;
	localparam int DSH_W  = NUM_W + OUT_BITS;
	localparam int QCNT_W = $clog2(QUO_W);

	localparam int REG_IDX_W = $clog2(NUM_REGS);
	localparam int APB_DW    = 64;
	localparam int ADDR_W    = REG_IDX_W + 3;

	localparam int IN_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((4 * OUT_BITS + 7) / 8) * 8;

	localparam logic [REG_IDX_W-1:0] REG_H00 = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_H01 = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_H02 = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_H10 = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_H11 = REG_IDX_W'(4);
	localparam logic [REG_IDX_W-1:0] REG_H12 = REG_IDX_W'(5);
	localparam logic [REG_IDX_W-1:0] REG_H20 = REG_IDX_W'(6);
	localparam logic [REG_IDX_W-1:0] REG_H21 = REG_IDX_W'(7);

	localparam logic [COEF_W-1:0] COEF_ONE = {{(COEF_W-1){1'b0}}, 1'b1} << COEF_FRAC_BITS;
	localparam logic [ACC_W-1:0]  ACC_ONE  = {{(ACC_W-1){1'b0}}, 1'b1} << COEF_FRAC_BITS;

	localparam logic [OUT_BITS-1:0] RUN_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
	localparam logic [OUT_BITS-1:0] RUN_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

	typedef struct packed {
		logic                       ok;
		logic signed [OUT_BITS-1:0] q;
	} div_res_t;

endpackage

FILE: rtl/hbb_div.sv
// ----------------------------------------------------------------------------
// hbb_div: rounded signed divider, one quotient bit per cycle
// Computes round-half-away(n / d) with range and zero-divisor checks.
// ----------------------------------------------------------------------------
module hbb_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [hbb_pkg::ACC_W-1:0] n,
	input  logic signed [hbb_pkg::ACC_W-1:0] d,
	output logic                           done,
	output hbb_pkg::div_res_t              res
);
	import hbb_pkg::*;

	logic [ACC_W-1:0]  n_mag, d_mag;
	logic [NUM_W-1:0]  num_init, den_init;
	logic [NUM_W-1:0]  rem_q;
	logic [DSH_W-1:0]  dsh_q;
	logic [QUO_W-1:0]  quo_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              busy_q, done_q, neg_q, zero_q;
	logic              ge;
	logic [QUO_W-1:0]  limit;

	assign n_mag    = n[ACC_W-1] ? (~n + ACC_W'(1)) : n;
	assign d_mag    = d[ACC_W-1] ? (~d + ACC_W'(1)) : d;
	assign num_init = {n_mag, 1'b0} + {1'b0, d_mag};
	assign den_init = {d_mag, 1'b0};

	// Trial subtract: shifted divisor must fit below the remainder width
	assign ge = (dsh_q[DSH_W-1:NUM_W] == '0) && (rem_q >= dsh_q[NUM_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= QCNT_W'(QUO_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - QCNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num_init;
			dsh_q  <= {den_init, {OUT_BITS{1'b0}}};
			quo_q  <= '0;
			neg_q  <= n[ACC_W-1] ^ d[ACC_W-1];
			zero_q <= (d == '0);
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q[NUM_W-1:0];
			end
			quo_q <= {quo_q[QUO_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	// Negative results may reach one step further than positive ones
	assign limit  = neg_q ? (QUO_W'(1) << (OUT_BITS - 1))
	                      : ((QUO_W'(1) << (OUT_BITS - 1)) - QUO_W'(1));
	assign done   = done_q;
	assign res.ok = !zero_q && (quo_q <= limit);
	assign res.q  = neg_q ? (~quo_q[OUT_BITS-1:0] + OUT_BITS'(1)) : quo_q[OUT_BITS-1:0];

endmodule

FILE: rtl/homography_bounding_box_unit.sv
// ----------------------------------------------------------------------------
// homography_bounding_box_unit: projected bounding box of a point stream
// Maps source points through a 3x3 homography and tracks min/max extents.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one item per source point, src_x/src_y in s_tdata and
//   the end-of-image marker in s_tlast. Output stream m_*: one item per
//   image, emitted after the point marked last; the four box edges travel
//   in m_tdata and the overflow status in m_tuser.
//   APB port: eight 48-bit homography coefficients at byte address 8*i; write
//   them only while the unit is idle (the unit itself does not enforce this).
//   Each point passes, from its accept to the earliest accept of the next
//   point, through the shared multiplier (six products plus one accumulate),
//   then two divisions on one shared restoring divider (x, then y), then the
//   fold into the running box and the return to idle.
//   s_tready is low meanwhile.
//   The box item appears in the output register at the end of the fold of
//   the last point. It may wait there while the next image runs; only the
//   fold of a later last point stalls until the receiver takes it.
//   Reset: coefficients return to identity, running extents and the
//   overflow flag are cleared, the output register empties.
// ----------------------------------------------------------------------------
module homography_bounding_box_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// APB configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [hbb_pkg::ADDR_W-1:0]        paddr,
	input  logic [hbb_pkg::APB_DW-1:0]        pwdata,
	output logic [hbb_pkg::APB_DW-1:0]        prdata,
	output logic                              pready,
	// point stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [hbb_pkg::IN_DATA_W-1:0]     s_tdata,   // src_x, src_y
	input  logic                              s_tlast,   // last_point
	// box stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [hbb_pkg::OUT_DATA_W-1:0]    m_tdata,   // box_left, box_top, box_right, box_bottom
	output logic                              m_tuser    // status
);
	import hbb_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIVX,
		S_DIVY,
		S_FOLD
	} state_t;

	state_t state_q;

	// coefficient registers
	logic [COEF_W-1:0] h00_q, h01_q, h02_q, h10_q, h11_q, h12_q, h20_q, h21_q;

	// point and arithmetic datapath
	logic [COORD_BITS-1:0]      x_q, y_q;
	logic                       last_q;
	logic [2:0]                 cnt_q;
	logic signed [COEF_W-1:0]   mul_a;
	logic signed [COORD_BITS:0] mul_b;
	logic signed [PROD_W-1:0]   mul_p;
	logic [ACC_W-1:0]           prod_q;
	logic [ACC_W-1:0]           acc_d_q, acc_x_q, acc_y_q;

	// divider
	logic              div_go_q;
	logic              div_done;
	div_res_t          div_res;
	logic [ACC_W-1:0]  div_n;

	logic signed [OUT_BITS-1:0] px_q, py_q;
	logic                       okx_q;

	// running box
	logic signed [OUT_BITS-1:0] run_left_q, run_top_q, run_right_q, run_bottom_q;
	logic                       ovf_seen_q;
	logic signed [OUT_BITS-1:0] new_left, new_top, new_right, new_bottom;
	logic                       pt_ok, new_ovf;

	// output register
	logic                       m_tvalid_q;
	logic [OUT_DATA_W-1:0]      m_tdata_q;
	logic                       m_tuser_q;
	logic                       out_free;
	logic                       out_load;

	logic                       in_acc, cfg_wr;

	assign in_acc   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign cfg_wr   = psel && penable && pwrite;
	assign pready   = 1'b1;
	assign out_free = !m_tvalid_q || m_tready;
	// load the box item at the fold of a last point once the register frees
	assign out_load = (state_q == S_FOLD) && last_q && out_free;

	// ---------------- configuration registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h00_q <= COEF_ONE;
			h01_q <= '0;
			h02_q <= '0;
			h10_q <= '0;
			h11_q <= COEF_ONE;
			h12_q <= '0;
			h20_q <= '0;
			h21_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[ADDR_W-1:3])
				REG_H00: h00_q <= pwdata[COEF_W-1:0];
				REG_H01: h01_q <= pwdata[COEF_W-1:0];
				REG_H02: h02_q <= pwdata[COEF_W-1:0];
				REG_H10: h10_q <= pwdata[COEF_W-1:0];
				REG_H11: h11_q <= pwdata[COEF_W-1:0];
				REG_H12: h12_q <= pwdata[COEF_W-1:0];
				REG_H20: h20_q <= pwdata[COEF_W-1:0];
				REG_H21: h21_q <= pwdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back sign-extended to the bus width
	always_comb begin
		logic [COEF_W-1:0] rd;
		case (paddr[ADDR_W-1:3])
			REG_H00: rd = h00_q;
			REG_H01: rd = h01_q;
			REG_H02: rd = h02_q;
			REG_H10: rd = h10_q;
			REG_H11: rd = h11_q;
			REG_H12: rd = h12_q;
			REG_H20: rd = h20_q;
			REG_H21: rd = h21_q;
			default: rd = '0;
		endcase
		prdata = {{(APB_DW-COEF_W){rd[COEF_W-1]}}, rd};
	end

	// ---------------- shared multiplier ----------------
	// Order: denominator terms first, then x numerator, then y numerator.
	always_comb begin
		case (cnt_q)
			3'd0:    mul_a = h20_q;
			3'd1:    mul_a = h21_q;
			3'd2:    mul_a = h00_q;
			3'd3:    mul_a = h01_q;
			3'd4:    mul_a = h10_q;
			3'd5:    mul_a = h11_q;
			default: mul_a = '0;
		endcase
		mul_b = cnt_q[0] ? {1'b0, y_q} : {1'b0, x_q};
		mul_p = mul_a * mul_b;
	end

	assign div_n = (state_q == S_DIVY) ? acc_y_q : acc_x_q;

	hbb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.n      (div_n),
		.d      (acc_d_q),
		.done   (div_done),
		.res    (div_res)
	);

	// ---------------- fold into the running box ----------------
	always_comb begin
		pt_ok      = okx_q && div_res.ok;
		new_left   = (pt_ok && (px_q < run_left_q))      ? px_q        : run_left_q;
		new_right  = (pt_ok && (px_q > run_right_q))     ? px_q        : run_right_q;
		new_top    = (pt_ok && (py_q < run_top_q))       ? py_q        : run_top_q;
		new_bottom = (pt_ok && (py_q > run_bottom_q))    ? py_q        : run_bottom_q;
		new_ovf    = ovf_seen_q || !pt_ok;
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			div_go_q     <= 1'b0;
			run_left_q   <= RUN_MAX;
			run_top_q    <= RUN_MAX;
			run_right_q  <= RUN_MIN;
			run_bottom_q <= RUN_MIN;
			ovf_seen_q   <= 1'b0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_tuser_q    <= 1'b0;
		end else begin
			// start the x division after the last accumulate, y right after x
			div_go_q   <= ((state_q == S_MUL) && (cnt_q == 3'd6)) ||
			              ((state_q == S_DIVX) && div_done);
			m_tvalid_q <= out_load || (m_tvalid_q && !m_tready);
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cnt_q   <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd6) begin
						state_q  <= S_DIVX;
					end
				end
				S_DIVX: begin
					if (div_done) begin
						state_q  <= S_DIVY;
					end
				end
				S_DIVY: begin
					if (div_done) begin
						state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					// px_q/okx_q hold x; the y ok flag is read from the divider
					if (!last_q) begin
						run_left_q   <= new_left;
						run_top_q    <= new_top;
						run_right_q  <= new_right;
						run_bottom_q <= new_bottom;
						ovf_seen_q   <= new_ovf;
						state_q      <= S_IDLE;
					end else if (out_free) begin
						if (new_ovf) begin
							m_tdata_q <= '0;
							m_tuser_q <= 1'b1;
						end else begin
							m_tdata_q <= OUT_DATA_W'({new_bottom, new_right, new_top, new_left});
							m_tuser_q <= 1'b0;
						end
						run_left_q   <= RUN_MAX;
						run_top_q    <= RUN_MAX;
						run_right_q  <= RUN_MIN;
						run_bottom_q <= RUN_MIN;
						ovf_seen_q   <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q     <= s_tdata[COORD_BITS-1:0];
			y_q     <= s_tdata[2*COORD_BITS-1:COORD_BITS];
			last_q  <= s_tlast;
			acc_d_q <= ACC_ONE;
			acc_x_q <= {{(ACC_W-COEF_W){h02_q[COEF_W-1]}}, h02_q};
			acc_y_q <= {{(ACC_W-COEF_W){h12_q[COEF_W-1]}}, h12_q};
		end
		if (state_q == S_MUL) begin
			prod_q <= {{(ACC_W-PROD_W){mul_p[PROD_W-1]}}, mul_p};
			// accumulate the product registered in the previous cycle
			case (cnt_q)
				3'd1, 3'd2: acc_d_q <= acc_d_q + prod_q;
				3'd3, 3'd4: acc_x_q <= acc_x_q + prod_q;
				3'd5, 3'd6: acc_y_q <= acc_y_q + prod_q;
				default: ;
			endcase
		end
		if (state_q == S_DIVX && div_done) begin
			px_q  <= div_res.q;
			okx_q <= div_res.ok;
		end
		if (state_q == S_DIVY && div_done) begin
			py_q <= div_res.q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
